>>> rtl/label_overlap_counter_assert.svh
// ----------------------------------------------------------------------------
// label overlap counter assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LABEL_OVERLAP_COUNTER_ASSERT_SVH
`define LABEL_OVERLAP_COUNTER_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define LOVC_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define LOVC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define LOVC_ASSERT_SAME(name, clk, rst, ante, cons)
`define LOVC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> rtl/lovc_pkg.sv
// ----------------------------------------------------------------------------
// lovc_pkg
// shared sizes, types and helpers of the label overlap counter
// ----------------------------------------------------------------------------
package lovc_pkg;

  localparam int LABEL_BITS    = 8;
  localparam int COUNT_BITS    = 32;
  localparam int LABEL_DEPTH   = 1 << LABEL_BITS;
  localparam int LABEL_FIELD_W = 8;
  localparam int COUNT_FIELD_W = 32;

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_READ       = 1'b1;

  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // one table row per label
  typedef struct packed {
    count_t first_only;
    count_t second_only;
    count_t both;
  } row_t;

  localparam int ROW_BITS = $bits(row_t);

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_sel_b;
    logic wr_a;
    logic wr_b;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic same_label;
  } ctrl_stat_t;

  function automatic label_t to_label(input logic [LABEL_FIELD_W-1:0] f);
    logic [31:0] t;
    t = 32'(f);
    return t[LABEL_BITS-1:0];
  endfunction

  function automatic logic [LABEL_FIELD_W-1:0] label_field(input label_t l);
    logic [31:0] t;
    t = 32'(l);
    return t[LABEL_FIELD_W-1:0];
  endfunction

  function automatic logic [COUNT_FIELD_W-1:0] count_field(input count_t c);
    logic [63:0] t;
    t = 64'(c);
    return t[COUNT_FIELD_W-1:0];
  endfunction

  // saturating increment
  function automatic count_t bump(input count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

endpackage

>>> rtl/lovc_if.sv
// ----------------------------------------------------------------------------
// lovc channel interfaces
// request channel (pixel pairs and label reads) and result channel
// ----------------------------------------------------------------------------
interface lovc_pixel_if import lovc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [LABEL_FIELD_W-1:0] label_first;
  logic [LABEL_FIELD_W-1:0] label_second;

  modport source (output valid, command, label_first, label_second, input ready);
  modport sink   (input valid, command, label_first, label_second, output ready);
endinterface

interface lovc_result_if import lovc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [LABEL_FIELD_W-1:0] read_label;
  logic                     label_seen;
  logic [COUNT_FIELD_W-1:0] count_first_only;
  logic [COUNT_FIELD_W-1:0] count_second_only;
  logic [COUNT_FIELD_W-1:0] count_both;

  modport source (output valid, read_label, label_seen, count_first_only,
                  count_second_only, count_both, input ready);
  modport sink   (input valid, read_label, label_seen, count_first_only,
                  count_second_only, count_both, output ready);
endinterface

>>> rtl/lovc_ram.sv
// ----------------------------------------------------------------------------
// lovc_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lovc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/lovc_dp.sv
// ----------------------------------------------------------------------------
// lovc_dp
// datapath: label registers, count table, row valid bits, result register
// ----------------------------------------------------------------------------
module lovc_dp import lovc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  output ctrl_stat_t               stat,
  input  logic                     command,
  input  logic [LABEL_FIELD_W-1:0] label_first,
  input  logic [LABEL_FIELD_W-1:0] label_second,
  output logic [LABEL_FIELD_W-1:0] read_label,
  output logic                     label_seen,
  output logic [COUNT_FIELD_W-1:0] count_first_only,
  output logic [COUNT_FIELD_W-1:0] count_second_only,
  output logic [COUNT_FIELD_W-1:0] count_both
);

  logic                   cmd_read;
  label_t                 lbl_a;
  label_t                 lbl_b;
  logic [LABEL_DEPTH-1:0] row_valid;
  logic                   rd_valid;
  label_t                 rd_addr;
  label_t                 wr_addr;
  logic                   wr_en;
  logic [ROW_BITS-1:0]    rd_data;
  row_t                   row_cur;
  row_t                   row_upd;
  label_t                 res_label;
  logic                   res_seen;
  row_t                   res_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_read <= (command == CMD_READ);
      lbl_a    <= to_label(label_first);
      lbl_b    <= to_label(label_second);
    end
    if (cmd.rd_en) begin
      rd_valid <= row_valid[rd_addr];
    end
    if (cmd.load_out) begin
      res_label <= lbl_a;
      res_seen  <= rd_valid;
      res_row   <= row_cur;
    end
  end

  // a row never written reads as all zero counts, not seen
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_addr = cmd.rd_sel_b ? lbl_b : lbl_a;
  assign wr_addr = cmd.wr_b ? lbl_b : lbl_a;
  assign wr_en   = cmd.wr_a | cmd.wr_b;

  lovc_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (LABEL_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (row_upd),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    row_cur = rd_valid ? row_t'(rd_data) : '0;
    row_upd = row_cur;
    if (cmd.wr_b) begin
      row_upd.second_only = bump(row_cur.second_only);
    end else if (stat.same_label) begin
      row_upd.both = bump(row_cur.both);
    end else begin
      row_upd.first_only = bump(row_cur.first_only);
    end
  end

  assign stat = '{is_read: cmd_read, same_label: (lbl_a == lbl_b)};

  assign read_label        = label_field(res_label);
  assign label_seen        = res_seen;
  assign count_first_only  = count_field(res_row.first_only);
  assign count_second_only = count_field(res_row.second_only);
  assign count_both        = count_field(res_row.both);

endmodule

>>> rtl/lovc_ctrl.sv
// ----------------------------------------------------------------------------
// lovc_ctrl
// controller: sequences read-modify-write of table rows and result handoff
// ----------------------------------------------------------------------------
`include "label_overlap_counter_assert.svh"

module lovc_ctrl import lovc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_ready,
  output logic       result_valid,
  input  logic       result_ready,
  output ctrl_cmd_t  cmd,
  input  ctrl_stat_t stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK_A = 3'd1;
  localparam logic [2:0] S_UPD_A  = 3'd2;
  localparam logic [2:0] S_LOOK_B = 3'd3;
  localparam logic [2:0] S_UPD_B  = 3'd4;
  localparam logic [2:0] S_SEND   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    pixel_ready  = (state == S_IDLE);
    result_valid = (state == S_SEND);
    case (state)
      S_IDLE: begin
        if (pixel_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK_A;
        end
      end
      S_LOOK_A: begin
        cmd.rd_en  = 1'b1;
        state_next = S_UPD_A;
      end
      S_UPD_A: begin
        if (stat.is_read) begin
          cmd.load_out = 1'b1;
          state_next   = S_SEND;
        end else begin
          cmd.wr_a   = 1'b1;
          // differing labels also bump the second label's row
          state_next = stat.same_label ? S_IDLE : S_LOOK_B;
        end
      end
      S_LOOK_B: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel_b = 1'b1;
        state_next   = S_UPD_B;
      end
      S_UPD_B: begin
        cmd.wr_b   = 1'b1;
        state_next = S_IDLE;
      end
      S_SEND: begin
        if (result_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `LOVC_ASSERT_NEXT(a_accept_reads, clk, rst, pixel_valid && pixel_ready, cmd.rd_en && !cmd.rd_sel_b)
  `LOVC_ASSERT_SAME(a_second_after_first, clk, rst, cmd.wr_b, $past(cmd.wr_a, 2))
  `LOVC_ASSERT_SAME(a_second_labels_differ, clk, rst, cmd.wr_b, !stat.same_label && !stat.is_read)
  `LOVC_ASSERT_NEXT(a_result_follows_load, clk, rst, cmd.load_out, result_valid && !pixel_ready)

endmodule

>>> rtl/label_overlap_counter.sv
// ----------------------------------------------------------------------------
// label_overlap_counter
// per-label overlap counts of two label images, with label read-back
// ----------------------------------------------------------------------------
// Requests are taken one at a time. An accumulate request updates the first
// label's row and, when the labels differ, then the second's; a read request
// shows its result after its row lookup and holds it until the result is
// taken, and the next request can be taken the cycle after that. This comes
// from the count table being one memory with a single read and a single
// write port: each touched label row is read, bumped and written back in
// turn. The table needs no clearing pass after reset, since a valid bit per
// label makes unwritten rows read as zero counts and not seen.
// ----------------------------------------------------------------------------
module label_overlap_counter import lovc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  lovc_pixel_if.sink    pixel,
  lovc_result_if.source result
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  lovc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel.valid),
    .pixel_ready  (pixel.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  lovc_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .command           (pixel.command),
    .label_first       (pixel.label_first),
    .label_second      (pixel.label_second),
    .read_label        (result.read_label),
    .label_seen        (result.label_seen),
    .count_first_only  (result.count_first_only),
    .count_second_only (result.count_second_only),
    .count_both        (result.count_both)
  );

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the label overlap counter: pixel-pair and read
// requests are replayed against an in-bench count table, and every read
// result is compared field by field under random idling and a long stall
// ----------------------------------------------------------------------------
module tb_top import lovc_pkg::*; ();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEMS_PHASE  = 400;
  localparam int POOL_SIZE    = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    logic                     command;
    logic [LABEL_FIELD_W-1:0] label_first;
    logic [LABEL_FIELD_W-1:0] label_second;
  } pixel_req_t;

  typedef struct {
    logic [LABEL_FIELD_W-1:0] read_label;
    logic                     label_seen;
    logic [COUNT_FIELD_W-1:0] count_first_only;
    logic [COUNT_FIELD_W-1:0] count_second_only;
    logic [COUNT_FIELD_W-1:0] count_both;
  } label_report_t;

  logic clk;
  logic rst;

  lovc_pixel_if  pixel ();
  lovc_result_if result ();

  label_overlap_counter i_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .result (result)
  );

  // bench copy of the per-label table
  logic   seen_tbl        [LABEL_DEPTH];
  count_t first_only_tbl  [LABEL_DEPTH];
  count_t second_only_tbl [LABEL_DEPTH];
  count_t both_tbl        [LABEL_DEPTH];

  pixel_req_t    pending_reqs[$];
  label_report_t pending_reports[$];
  logic [LABEL_FIELD_W-1:0] label_pool [POOL_SIZE];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  pressure_phase;
  bit  held_once;
  int  hold_left;
  int  mismatches;
  int  cycle_count;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic count_t sat_inc(input count_t c);
    if (c == {COUNT_BITS{1'b1}}) begin
      return c;
    end
    return c + 1'b1;
  endfunction

  // update the table for one taken request and queue the read result
  function automatic void apply_request(input pixel_req_t req);
    label_t        la;
    label_t        lb;
    label_report_t rep;
    la = req.label_first[LABEL_BITS-1:0];
    lb = req.label_second[LABEL_BITS-1:0];
    if (req.command == CMD_ACCUMULATE) begin
      seen_tbl[la] = 1'b1;
      seen_tbl[lb] = 1'b1;
      if (la == lb) begin
        both_tbl[la] = sat_inc(both_tbl[la]);
      end else begin
        first_only_tbl[la]  = sat_inc(first_only_tbl[la]);
        second_only_tbl[lb] = sat_inc(second_only_tbl[lb]);
      end
    end else begin
      rep.read_label        = LABEL_FIELD_W'(la);
      rep.label_seen        = seen_tbl[la];
      rep.count_first_only  = COUNT_FIELD_W'(first_only_tbl[la]);
      rep.count_second_only = COUNT_FIELD_W'(second_only_tbl[la]);
      rep.count_both        = COUNT_FIELD_W'(both_tbl[la]);
      pending_reports = {pending_reports, rep};
    end
  endfunction

  function automatic logic [LABEL_FIELD_W-1:0] pick_label();
    if ($urandom_range(99) < 60) begin
      return label_pool[$urandom_range(POOL_SIZE - 1)];
    end
    return LABEL_FIELD_W'($urandom);
  endfunction

  function automatic pixel_req_t random_request();
    pixel_req_t req;
    req.command      = ($urandom_range(99) < 25) ? CMD_READ : CMD_ACCUMULATE;
    req.label_first  = pick_label();
    req.label_second = pick_label();
    if (req.command == CMD_ACCUMULATE && $urandom_range(99) < 25) begin
      req.label_second = req.label_first;
    end
    return req;
  endfunction

  task automatic push_req(input logic cmd, input logic [7:0] la, input logic [7:0] lb);
    pixel_req_t req;
    req.command      = cmd;
    req.label_first  = la;
    req.label_second = lb;
    pending_reqs = {pending_reqs, req};
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    pixel_req_t req;
    if (rst) begin
      pixel.valid <= 1'b0;
    end else begin
      if (pixel.valid && pixel.ready) begin
        req.command      = pixel.command;
        req.label_first  = pixel.label_first;
        req.label_second = pixel.label_second;
        apply_request(req);
      end
      if (!pixel.valid || pixel.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_reqs.pop_front();
          pixel.valid        <= 1'b1;
          pixel.command      <= req.command;
          pixel.label_first  <= req.label_first;
          pixel.label_second <= req.label_second;
        end else begin
          pixel.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted once in the pressure phase
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      held_once <= 1'b0;
    end else if (pressure_phase && !held_once) begin
      held_once <= 1'b1;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    label_report_t rep;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (pending_reports.size() == 0) begin
          $error("read result for label %0d with no request waiting", result.read_label);
          mismatches++;
        end else begin
          rep = pending_reports.pop_front();
          check_field("read_label", 64'(rep.read_label), 64'(result.read_label));
          check_field("label_seen", 64'(rep.label_seen), 64'(result.label_seen));
          check_field("count_first_only", 64'(rep.count_first_only),
                      64'(result.count_first_only));
          check_field("count_second_only", 64'(rep.count_second_only),
                      64'(result.count_second_only));
          check_field("count_both", 64'(rep.count_both), 64'(result.count_both));
        end
      end
      if ((pressure_phase && !held_once) || hold_left > 0) begin
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("label_overlap_counter: mismatch");
      $finish;
    end
  end

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      pending_reqs = {pending_reqs, random_request()};
    end
    while (pending_reqs.size() > 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    rst                = 1'b1;
    pixel.valid        = 1'b0;
    pixel.command      = CMD_ACCUMULATE;
    pixel.label_first  = '0;
    pixel.label_second = '0;
    result.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    pressure_phase     = 1'b0;
    mismatches         = 0;
    cycle_count        = 0;
    for (int i = 0; i < LABEL_DEPTH; i++) begin
      seen_tbl[i]        = 1'b0;
      first_only_tbl[i]  = '0;
      second_only_tbl[i] = '0;
      both_tbl[i]        = '0;
    end
    label_pool[0] = 8'h00;
    label_pool[1] = 8'hFF;
    for (int i = 2; i < POOL_SIZE; i++) begin
      label_pool[i] = LABEL_FIELD_W'($urandom);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: untouched labels, extremes, label zero, repeated labels
    push_req(CMD_READ, 8'h00, 8'hFF);
    push_req(CMD_READ, 8'hFF, 8'h00);
    push_req(CMD_ACCUMULATE, 8'h00, 8'h00);
    push_req(CMD_ACCUMULATE, 8'hFF, 8'hFF);
    push_req(CMD_ACCUMULATE, 8'h00, 8'hFF);
    push_req(CMD_ACCUMULATE, 8'hFF, 8'h00);
    push_req(CMD_ACCUMULATE, 8'hAA, 8'h55);
    push_req(CMD_ACCUMULATE, 8'h55, 8'hAA);
    push_req(CMD_ACCUMULATE, 8'h01, 8'h01);
    push_req(CMD_READ, 8'h00, 8'h00);
    push_req(CMD_READ, 8'hFF, 8'hFF);
    push_req(CMD_READ, 8'hAA, 8'h55);
    push_req(CMD_READ, 8'h55, 8'hAA);
    push_req(CMD_READ, 8'h01, 8'h01);
    push_req(CMD_READ, 8'h02, 8'hFF);
    // back-to-back hits on one row
    push_req(CMD_ACCUMULATE, 8'h07, 8'h07);
    push_req(CMD_ACCUMULATE, 8'h07, 8'h07);
    push_req(CMD_ACCUMULATE, 8'h07, 8'h07);
    push_req(CMD_ACCUMULATE, 8'h07, 8'h09);
    push_req(CMD_ACCUMULATE, 8'h09, 8'h07);
    push_req(CMD_READ, 8'h07, 8'h09);
    push_req(CMD_READ, 8'h09, 8'h07);
    push_req(CMD_READ, 8'h07, 8'h07);
    while (pending_reqs.size() > 0) begin
      @(negedge clk);
    end

    run_phase(0, 0, ITEMS_PHASE);
    run_phase(83, 0, ITEMS_PHASE);
    run_phase(0, 83, ITEMS_PHASE);
    run_phase(34, 34, ITEMS_PHASE);
    // receiver holds off while requests keep coming
    pressure_phase = 1'b1;
    run_phase(0, 0, 60);

    while (pending_reqs.size() > 0 || pixel.valid || pending_reports.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("label_overlap_counter: match");
    end else begin
      $display("label_overlap_counter: mismatch");
    end
    $finish;
  end

endmodule
